// ----- hdl/mpsd_pkg.sv -----
// shared types and constants of the pixel set distance core
`timescale 1ns / 1ps

package mpsd_pkg;

  localparam int ACTION_W = 2;
  localparam int PIX_W    = 12;
  localparam int VALUE_W  = 8;
  localparam int MODE_W   = 2;
  localparam int DIST_W   = 21;
  localparam int ABS_W    = 17;   // local + origin, wide enough for the sum of two 12-bit values

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [ACTION_W-1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_DX   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EUCL = 2'd2;

  typedef struct packed {
    logic load;        // pixel transaction accepted
    logic start;       // compute transaction accepted
    logic issue;       // read one pair this cycle
    logic sqrt_start;
    logic sqrt_step;
    logic finish;      // load result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;        // empty set or unused mode
    logic last_pair;
    logic pipe_idle;
    logic root_mode;
    logic sqrt_done;
  } ctrl_stat_t;

endpackage

// ----- hdl/mpsd_if.sv -----
// channel interfaces for pixel transactions and result transactions
`timescale 1ns / 1ps

interface mpsd_in_if;
  import mpsd_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [PIX_W-1:0]    pixel_x;
  logic [PIX_W-1:0]    pixel_y;
  logic [VALUE_W-1:0]  pixel_value;
  logic [PIX_W-1:0]    origin_x;
  logic [PIX_W-1:0]    origin_y;
  logic [MODE_W-1:0]   distance_mode;
  modport source (output valid, action, pixel_x, pixel_y, pixel_value, origin_x, origin_y,
                  distance_mode, input ready);
  modport sink (input valid, action, pixel_x, pixel_y, pixel_value, origin_x, origin_y,
                distance_mode, output ready);
endinterface

interface mpsd_out_if;
  import mpsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] min_distance;
  logic              empty_set;
  logic              overflow;
  modport source (output valid, min_distance, empty_set, overflow, input ready);
  modport sink (input valid, min_distance, empty_set, overflow, output ready);
endinterface

// ----- hdl/mpsd_sqrt.sv -----
// bit-serial integer square root, one result bit per step
`timescale 1ns / 1ps

module mpsd_sqrt #(
  parameter int OP_W = 50
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                step,
  input  logic [OP_W-1:0]     operand,
  output logic [OP_W/2-1:0]   root,
  output logic                done
);
  localparam int R  = OP_W / 2;
  localparam int CW = $clog2(R + 1);

  logic [OP_W-1:0] op;
  logic [R+1:0]    rem;
  logic [CW-1:0]   cnt;
  logic [R+3:0]    rem_t;
  logic [R+3:0]    trial;

  assign rem_t = {rem, op[OP_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign done  = (cnt == CW'(R));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= CW'(R);
    end else if (start) begin
      op   <= operand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (step && !done) begin
      op  <= op << 2;
      cnt <= cnt + 1'b1;
      if (rem_t >= trial) begin
        rem  <= (R+2)'(rem_t - trial);
        root <= {root[R-2:0], 1'b1};
      end else begin
        rem  <= rem_t[R+1:0];
        root <= {root[R-2:0], 1'b0};
      end
    end
  end
endmodule

// ----- hdl/mpsd_ctrl.sv -----
// sequencing state machine: load, pair scan, drain, root, result
`timescale 1ns / 1ps

module mpsd_ctrl import mpsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_is_compute,
  output logic       in_ready,
  output logic       res_valid,
  input  logic       res_ready,
  output ctrl_cmd_t  cmd,
  input  ctrl_stat_t stat
);
  typedef enum logic [2:0] {IDLE, SCAN, DRAIN, ROOT, FINISH} state_t;
  state_t state;
  logic   acc;

  assign in_ready = (state == IDLE) && (!in_is_compute || !res_valid);
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    cmd.load       = acc && !in_is_compute;
    cmd.start      = acc && in_is_compute;
    cmd.issue      = (state == SCAN) && !stat.skip;
    cmd.sqrt_start = (state == DRAIN) && stat.pipe_idle && stat.root_mode;
    cmd.sqrt_step  = (state == ROOT) && !stat.sqrt_done;
    cmd.finish     = (state == FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (acc && in_is_compute) state <= SCAN;
        end
        SCAN: begin
          if (stat.skip) state <= FINISH;
          else if (stat.last_pair) state <= DRAIN;
        end
        DRAIN: begin
          if (stat.pipe_idle) state <= stat.root_mode ? ROOT : FINISH;
        end
        ROOT: begin
          if (stat.sqrt_done) state <= FINISH;
        end
        FINISH: begin
          res_valid <= 1'b1;
          state     <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/mpsd_dpath.sv -----
// point stores, pair scan pipeline, running minimum and result formatting
`timescale 1ns / 1ps

module mpsd_dpath import mpsd_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  output ctrl_stat_t          stat,
  input  logic [ACTION_W-1:0] action,
  input  logic [PIX_W-1:0]    pixel_x,
  input  logic [PIX_W-1:0]    pixel_y,
  input  logic [VALUE_W-1:0]  pixel_value,
  input  logic [PIX_W-1:0]    origin_x,
  input  logic [PIX_W-1:0]    origin_y,
  input  logic [MODE_W-1:0]   distance_mode,
  output logic [DIST_W-1:0]   min_distance,
  output logic                empty_set,
  output logic                overflow
);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PT_W  = 2 * COORD_BITS;
  localparam int D_W   = 2 * COORD_BITS + 1;
  localparam int SQ_IN = D_W + 16;
  localparam int SQ_W  = SQ_IN + (SQ_IN % 2);
  localparam int RT_W  = SQ_W / 2;
  localparam int LIN_W = D_W + 8;

  logic [PT_W-1:0] mem_a [MAX_POINTS];
  logic [PT_W-1:0] mem_b [MAX_POINTS];

  logic [CNT_W-1:0] count_a, count_b, snap_a, snap_b;
  logic             ovf, snap_ovf;
  logic [MODE_W-1:0] mode;
  logic             skip;
  logic [IDX_W-1:0] idx_i, idx_j;
  logic [PT_W-1:0]  pa, pb;
  logic             v1, v2;
  logic [D_W-1:0]   d2, best;
  logic [ABS_W-1:0] abs_x, abs_y;
  logic [PT_W-1:0]  new_pt;
  logic             black, full_a, full_b;
  logic [COORD_BITS-1:0] xa, ya, xb, yb, dx, dy;
  logic [RT_W-1:0]  root;
  logic             sqrt_done;
  logic [LIN_W-1:0] lin;
  logic [SQ_W-1:0]  sq_op;

  assign abs_x  = ABS_W'(pixel_x) + ABS_W'(origin_x);
  assign abs_y  = ABS_W'(pixel_y) + ABS_W'(origin_y);
  assign new_pt = {abs_y[COORD_BITS-1:0], abs_x[COORD_BITS-1:0]};
  assign black  = (pixel_value == '0);
  assign full_a = (count_a >= CNT_W'(MAX_POINTS));
  assign full_b = (count_b >= CNT_W'(MAX_POINTS));

  // point stores
  always_ff @(posedge clk) begin
    if (cmd.load && black && action == ACT_LOAD_A && !full_a)
      mem_a[count_a[IDX_W-1:0]] <= new_pt;
    if (cmd.load && black && action == ACT_LOAD_B && !full_b)
      mem_b[count_b[IDX_W-1:0]] <= new_pt;
    if (cmd.issue) begin
      pa <= mem_a[idx_i];
      pb <= mem_b[idx_j];
    end
  end

  // counts, snapshot and scan indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
      ovf     <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
    end else begin
      if (cmd.load && black && action == ACT_LOAD_A) begin
        if (full_a) ovf <= 1'b1;
        else count_a <= count_a + 1'b1;
      end
      if (cmd.load && black && action == ACT_LOAD_B) begin
        if (full_b) ovf <= 1'b1;
        else count_b <= count_b + 1'b1;
      end
      if (cmd.start) begin
        count_a <= '0;
        count_b <= '0;
        ovf     <= 1'b0;
      end
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      snap_a   <= count_a;
      snap_b   <= count_b;
      snap_ovf <= ovf;
      mode     <= distance_mode;
      skip     <= (count_a == '0) || (count_b == '0) ||
                  !(distance_mode == MODE_DX || distance_mode == MODE_DY ||
                    distance_mode == MODE_EUCL);
      idx_i    <= '0;
      idx_j    <= '0;
      best     <= '1;
    end else begin
      if (cmd.issue) begin
        if (CNT_W'(idx_j) == snap_b - 1'b1) begin
          idx_j <= '0;
          idx_i <= idx_i + 1'b1;
        end else begin
          idx_j <= idx_j + 1'b1;
        end
      end
      if (v2 && d2 < best) best <= d2;
    end
  end

  assign stat.last_pair = (CNT_W'(idx_i) == snap_a - 1'b1) && (CNT_W'(idx_j) == snap_b - 1'b1);
  assign stat.skip      = skip;
  assign stat.pipe_idle = !v1 && !v2;
  assign stat.root_mode = (mode == MODE_EUCL);
  assign stat.sqrt_done = sqrt_done;

  // per-pair measure
  assign xa = pa[COORD_BITS-1:0];
  assign ya = pa[PT_W-1:COORD_BITS];
  assign xb = pb[COORD_BITS-1:0];
  assign yb = pb[PT_W-1:COORD_BITS];
  assign dx = (xa > xb) ? xa - xb : xb - xa;
  assign dy = (ya > yb) ? ya - yb : yb - ya;

  always_ff @(posedge clk) begin
    if (v1) begin
      if (mode == MODE_DX) d2 <= D_W'(dx);
      else if (mode == MODE_DY) d2 <= D_W'(dy);
      else d2 <= D_W'(PT_W'(dx) * PT_W'(dx)) + D_W'(PT_W'(dy) * PT_W'(dy));
    end
  end

  // least squared distance with 16 fraction bits
  assign sq_op = SQ_W'({best, 16'd0});

  mpsd_sqrt #(.OP_W(SQ_W)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.sqrt_start),
    .step    (cmd.sqrt_step),
    .operand (sq_op),
    .root    (root),
    .done    (sqrt_done)
  );

  assign lin = {best, 8'd0};

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      empty_set <= skip;
      overflow  <= snap_ovf;
      if (skip) min_distance <= '0;
      else if (mode == MODE_EUCL)
        min_distance <= (root > RT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(root);
      else
        min_distance <= (lin > LIN_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(lin);
    end
  end
endmodule

// ----- hdl/min_pixel_set_distance_core.sv -----
// top level of the pixel set distance core
`timescale 1ns / 1ps

// least distance between two sets of black pixels. pixel transactions
// (action 0 or 1) store a black pixel at origin + local position in store a
// or b, one per cycle while the core is idle; a full store drops the pixel
// and raises a sticky overflow flag. a compute transaction (action 2) scans
// every pair of stored points through a three-stage read, measure and
// minimum pipeline at one pair per cycle; the euclidean measure then runs
// a bit-serial square root that gives 8 fraction bits, truncated. an empty
// store or mode 3 gives empty_set with distance 0. compute clears both
// stores and the overflow flag. pixel transactions are still taken while a
// result transaction waits; a compute transaction waits for it to go.
module min_pixel_set_distance_core import mpsd_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 13
) (
  input  logic       clk,
  input  logic       rst,
  mpsd_in_if.sink    pix_in,
  mpsd_out_if.source res_out
);
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // sequencing
  mpsd_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (pix_in.valid),
    .in_is_compute (pix_in.action == ACT_COMPUTE),
    .in_ready      (pix_in.ready),
    .res_valid     (res_out.valid),
    .res_ready     (res_out.ready),
    .cmd           (cmd),
    .stat          (stat)
  );

  // stores, pair pipeline and result register
  mpsd_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .action        (pix_in.action),
    .pixel_x       (pix_in.pixel_x),
    .pixel_y       (pix_in.pixel_y),
    .pixel_value   (pix_in.pixel_value),
    .origin_x      (pix_in.origin_x),
    .origin_y      (pix_in.origin_y),
    .distance_mode (pix_in.distance_mode),
    .min_distance  (res_out.min_distance),
    .empty_set     (res_out.empty_set),
    .overflow      (res_out.overflow)
  );
endmodule

// ----- tb/tb_min_pixel_set_distance_core.sv -----
// testbench for the pixel set distance core: random loads and computes checked against a predictor
`timescale 1ns / 1ps

module tb_min_pixel_set_distance_core;
  import mpsd_pkg::*;

  localparam int NPTS = 1024;
  localparam int CBITS = 13;
  localparam int WATCHDOG_LIMIT = 2000000;

  typedef struct packed {
    logic [DIST_W-1:0] dmin;
    logic              empty;
    logic              ovf;
  } dist_result_t;

  // predictor of the distance core plus a queue of pending compute answers
  class distance_scoreboard;
    logic [CBITS-1:0] ax[$], ay[$], bx[$], by[$];
    bit               ovf_seen;
    dist_result_t     pending[$];
    int               errors;
    int               checked;
    int               empties;

    function logic [63:0] root64(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_pixel_txn(logic [1:0] act, logic [11:0] px, logic [11:0] py,
                                 logic [7:0] pv, logic [11:0] ox, logic [11:0] oy,
                                 logic [1:0] md);
      logic [16:0] sx, sy;
      logic [63:0] best, d, dx, dy, dd;
      dist_result_t r;
      bit e;
      if (act == ACT_LOAD_A || act == ACT_LOAD_B) begin
        if (pv != 0) return;
        sx = px + ox;
        sy = py + oy;
        if (act == ACT_LOAD_A) begin
          if (ax.size() >= NPTS) ovf_seen = 1;
          else begin
            ax.insert(ax.size(), sx[CBITS-1:0]);
            ay.insert(ay.size(), sy[CBITS-1:0]);
          end
        end else begin
          if (bx.size() >= NPTS) ovf_seen = 1;
          else begin
            bx.insert(bx.size(), sx[CBITS-1:0]);
            by.insert(by.size(), sy[CBITS-1:0]);
          end
        end
        return;
      end
      if (act != ACT_COMPUTE) return;
      e = (ax.size() == 0 || bx.size() == 0 || md == 2'd3);
      d = 0;
      if (!e) begin
        best = '1;
        foreach (ax[i]) foreach (bx[j]) begin
          dx = (ax[i] > bx[j]) ? ax[i] - bx[j] : bx[j] - ax[i];
          dy = (ay[i] > by[j]) ? ay[i] - by[j] : by[j] - ay[i];
          if (md == MODE_DX) dd = dx;
          else if (md == MODE_DY) dd = dy;
          else dd = dx * dx + dy * dy;
          if (dd < best) best = dd;
        end
        d = (md == MODE_EUCL) ? root64(best << 16) : best << 8;
        if (d > DIST_MAX) d = DIST_MAX;
      end
      r.dmin = d[DIST_W-1:0];
      r.empty = e;
      r.ovf = ovf_seen;
      pending.insert(pending.size(), r);
      ax.delete(); ay.delete(); bx.delete(); by.delete();
      ovf_seen = 0;
    endfunction

    function void check_result(dist_result_t got);
      dist_result_t want;
      checked++;
      if (pending.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.empty) empties++;
      if (got.dmin !== want.dmin) begin
        $error("min_distance expected %0d actual %0d", want.dmin, got.dmin);
        errors++;
      end
      if (got.empty !== want.empty) begin
        $error("empty_set expected %0d actual %0d", want.empty, got.empty);
        errors++;
      end
      if (got.ovf !== want.ovf) begin
        $error("overflow expected %0d actual %0d", want.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  mpsd_in_if  pix_in();
  mpsd_out_if res_out();

  distance_scoreboard sb;

  // idle probability in percent for each side; zero during the steady stretch
  int  src_idle_pct;
  int  snk_idle_pct;
  bit  hold_sink;        // long receiver hold-off to back the core up
  int  quiet_cycles;
  int  n_items;

  min_pixel_set_distance_core #(
    .MAX_POINTS(NPTS),
    .COORD_BITS(CBITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .pix_in(pix_in.sink),
    .res_out(res_out.source)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        sb.note_pixel_txn(pix_in.action, pix_in.pixel_x, pix_in.pixel_y, pix_in.pixel_value,
                          pix_in.origin_x, pix_in.origin_y, pix_in.distance_mode);
      end
      if (res_out.valid && res_out.ready) begin
        sb.check_result({res_out.min_distance, res_out.empty_set, res_out.overflow});
      end
      if ((pix_in.valid && pix_in.ready) || (res_out.valid && res_out.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      // a long compute counts as quiet, so the limit covers the full pair scan
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[min_pixel_set_distance_core] ERROR");
        $finish;
      end
    end
  end

  // receiver ready, random idling, plus the hold-off stretch
  always @(negedge clk) begin
    if (rst || hold_sink)
      res_out.ready <= 1'b0;
    else
      res_out.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // send one transaction: random idle gap first, then hold valid until accepted
  task automatic send_pixel_txn(logic [1:0] act, logic [11:0] px, logic [11:0] py,
                                logic [7:0] pv, logic [11:0] ox, logic [11:0] oy,
                                logic [1:0] md);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(negedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.action <= act;
    pix_in.pixel_x <= px;
    pix_in.pixel_y <= py;
    pix_in.pixel_value <= pv;
    pix_in.origin_x <= ox;
    pix_in.origin_y <= oy;
    pix_in.distance_mode <= md;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    @(negedge clk);
    n_items++;
  endtask

  // random black-heavy pixel near a segment origin
  task automatic send_random_pixel(logic [1:0] act, logic [11:0] ox, logic [11:0] oy);
    logic [7:0] pv;
    pv = ($urandom_range(9) < 7) ? 8'd0 : 8'($urandom);
    send_pixel_txn(act, 12'($urandom_range(63)), 12'($urandom_range(63)), pv, ox, oy,
                   2'($urandom));
  endtask

  initial begin
    int nloads, rest, mode;
    logic [11:0] oxa, oya, oxb, oyb;
    sb = new();
    rst = 1;
    hold_sink = 0;
    n_items = 0;
    src_idle_pct = 31;
    snk_idle_pct = 31;
    pix_in.valid = 0;
    pix_in.action = '0;
    pix_in.pixel_x = '0;
    pix_in.pixel_y = '0;
    pix_in.pixel_value = '0;
    pix_in.origin_x = '0;
    pix_in.origin_y = '0;
    pix_in.distance_mode = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empty stores, then extreme coordinates at the top of the 13-bit range
    send_pixel_txn(ACT_COMPUTE, 0, 0, 0, 0, 0, MODE_DX);
    send_pixel_txn(ACT_LOAD_A, 12'hfff, 12'hfff, 0, 12'hfff, 12'hfff, 0);
    send_pixel_txn(ACT_COMPUTE, 0, 0, 0, 0, 0, MODE_EUCL);
    send_pixel_txn(ACT_LOAD_A, 0, 0, 0, 0, 0, 0);
    send_pixel_txn(ACT_LOAD_B, 12'hfff, 12'hfff, 0, 12'hfff, 12'hfff, 0);
    send_pixel_txn(ACT_LOAD_B, 12'hfff, 0, 8'hff, 0, 0, 0);   // non-black, ignored
    send_pixel_txn(2'd3, 12'hfff, 12'hfff, 0, 12'hfff, 12'hfff, 2'd3); // unused action
    send_pixel_txn(ACT_COMPUTE, 0, 0, 0, 0, 0, MODE_EUCL);    // saturates
    send_pixel_txn(ACT_LOAD_A, 12'd3, 12'd4, 0, 0, 0, 0);
    send_pixel_txn(ACT_LOAD_B, 0, 0, 0, 0, 0, 0);
    send_pixel_txn(ACT_LOAD_A, 12'd7, 0, 8'h80, 0, 0, 0);
    send_pixel_txn(ACT_COMPUTE, 0, 0, 0, 0, 0, MODE_DX);
    send_pixel_txn(ACT_LOAD_A, 12'd3, 12'd4, 0, 0, 0, 0);
    send_pixel_txn(ACT_LOAD_B, 0, 0, 0, 0, 0, 0);
    send_pixel_txn(ACT_COMPUTE, 0, 0, 0, 0, 0, MODE_DY);
    send_pixel_txn(ACT_LOAD_A, 12'd1, 12'd1, 0, 0, 0, 0);
    send_pixel_txn(ACT_LOAD_B, 12'd2, 12'd3, 0, 0, 0, 0);
    send_pixel_txn(ACT_COMPUTE, 0, 0, 0, 0, 0, MODE_EUCL);    // irrational root
    send_pixel_txn(ACT_LOAD_A, 1, 1, 0, 0, 0, 0);
    send_pixel_txn(ACT_LOAD_B, 1, 1, 0, 0, 0, 0);
    send_pixel_txn(ACT_COMPUTE, 0, 0, 0, 0, 0, 2'd3);         // unused mode

    // fill store a past capacity to raise overflow, with no idling
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (int k = 0; k < NPTS + 3; k++)
      send_pixel_txn(ACT_LOAD_A, 12'(k), 12'(k >> 5), 0, 0, 0, 0);
    send_pixel_txn(ACT_LOAD_B, 12'd2000, 12'd2000, 0, 0, 0, 0);
    send_pixel_txn(ACT_COMPUTE, 0, 0, 0, 0, 0, MODE_DX);

    // receiver holds off while computes back up against the input
    fork
      begin
        hold_sink = 1;
        repeat (400) @(negedge clk);
        hold_sink = 0;
      end
      begin
        for (int k = 0; k < 6; k++) begin
          send_pixel_txn(ACT_LOAD_A, 12'(k), 0, 0, 0, 0, 0);
          send_pixel_txn(ACT_LOAD_B, 0, 12'(k), 0, 0, 0, 0);
          send_pixel_txn(ACT_COMPUTE, 0, 0, 0, 0, 0, 2'(k % 3));
        end
      end
    join

    // random segments: small sets, a few empty ones, plus noise
    src_idle_pct = 31;
    snk_idle_pct = 31;
    rest = 0;
    while (n_items < 1900) begin
      if (rest == 0 && $urandom_range(9) == 0) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
        rest = 1;
      end else if (rest != 0 && $urandom_range(9) == 0) begin
        src_idle_pct = 31;
        snk_idle_pct = 31;
        rest = 0;
      end
      oxa = 12'($urandom);
      oya = 12'($urandom);
      if ($urandom_range(3) == 0) begin
        oxb = 12'($urandom);
        oyb = 12'($urandom);
      end else begin
        oxb = oxa + 12'($urandom_range(80));
        oyb = oya + 12'($urandom_range(80));
      end
      nloads = $urandom_range(12);
      for (int k = 0; k < nloads; k++) begin
        if ($urandom_range(19) == 0)
          send_pixel_txn(2'd3, 12'($urandom), 12'($urandom), 8'($urandom), 12'($urandom),
                         12'($urandom), 2'($urandom));
        else if ($urandom_range(1) == 0)
          send_random_pixel(ACT_LOAD_A, oxa, oya);
        else
          send_random_pixel(ACT_LOAD_B, oxb, oyb);
      end
      mode = ($urandom_range(19) == 0) ? 3 : $urandom_range(2);
      send_pixel_txn(ACT_COMPUTE, 12'($urandom), 12'($urandom), 8'($urandom), 12'($urandom),
                     12'($urandom), 2'(mode));
    end
    pix_in.valid <= 1'b0;

    // drain the pending queue, then wait for stragglers
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("run: %0d input transactions, %0d results checked, %0d with empty set",
             n_items, sb.checked, sb.empties);
    if (sb.errors == 0)
      $display("[min_pixel_set_distance_core] OK");
    else
      $display("[min_pixel_set_distance_core] ERROR");
    $finish;
  end

endmodule
